[rtl/core/gfrse_pkg.sv]
// ----------------------------------------------------------------------------
// gfrse_pkg
// Types, constants and a helper function shared by the symbol engine files.
// ----------------------------------------------------------------------------
`default_nettype none

package gfrse_pkg;

  localparam int SymW        = 16;
  localparam int NumCells    = 16;
  localparam int NarrowCells = 8;
  localparam int FuncW       = 3;
  localparam int CfgIdxW     = 2;

  localparam logic [15:0] Red16 = 16'h002D;
  localparam logic [7:0]  Red8  = 8'h1D;

  localparam logic [CfgIdxW-1:0] CfgFieldMode  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCoefFirst  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCoefSecond = 2'd2;

  typedef enum logic [FuncW-1:0] {
    FuncMac     = 3'd0,
    FuncDualMac = 3'd1,
    FuncMul     = 3'd2,
    FuncXor     = 3'd3,
    FuncBfly    = 3'd4,
    FuncInvBfly = 3'd5
  } func_e;

  typedef struct packed {
    func_e            func;
    logic [SymW-1:0]  src;
    logic [SymW-1:0]  dst;
    logic [SymW-1:0]  dst2;
    logic             last;
    logic [SymW-1:0]  mcand;
    logic [SymW-1:0]  acc1;
    logic [SymW-1:0]  acc2;
  } beat_t;

  // multiply by x in the selected field
  function automatic logic [SymW-1:0] gf_xtime(input logic [SymW-1:0] a, input logic wide);
    logic [SymW-1:0] r;
    if (wide) begin
      r = {a[14:0], 1'b0} ^ (a[15] ? Red16 : 16'h0000);
    end else begin
      r = {8'h00, {a[6:0], 1'b0} ^ (a[7] ? Red8 : 8'h00)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/gfrse_if.sv]
// ----------------------------------------------------------------------------
// gfrse_in_if / gfrse_out_if
// Valid/ready channels carrying symbol beats into and results out of the engine.
// ----------------------------------------------------------------------------
`default_nettype none

interface gfrse_in_if;
  import gfrse_pkg::*;
  logic                valid;
  logic                ready;
  logic [FuncW-1:0]    func;
  logic [SymW-1:0]     sym_src;
  logic [SymW-1:0]     sym_dst;
  logic [SymW-1:0]     sym_dst_two;
  logic                last_in;

  modport source (output valid, func, sym_src, sym_dst, sym_dst_two, last_in, input ready);
  modport sink   (input valid, func, sym_src, sym_dst, sym_dst_two, last_in, output ready);
endinterface

interface gfrse_out_if;
  import gfrse_pkg::*;
  logic                valid;
  logic                ready;
  logic [SymW-1:0]     res_first;
  logic [SymW-1:0]     res_second;
  logic                last_out;

  modport source (output valid, res_first, res_second, last_out, input ready);
  modport sink   (input valid, res_first, res_second, last_out, output ready);
endinterface

`default_nettype wire

[rtl/core/gfrse_cell.sv]
// ----------------------------------------------------------------------------
// gfrse_cell
// One shift-and-add step: folds one coefficient bit into both accumulators,
// advances the multiplicand by x and hands the beat to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module gfrse_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wide_i,
  input  wire logic           c1_bit_i,
  input  wire logic           c2_bit_i,
  input  wire logic           valid_i,
  input  gfrse_pkg::beat_t    beat_i,
  output logic                ready_o,
  output logic                valid_o,
  output gfrse_pkg::beat_t    beat_o,
  input  wire logic           ready_i
);
  import gfrse_pkg::*;

  logic  valid_q;
  beat_t beat_q, beat_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign beat_o  = beat_q;

  always_comb begin
    beat_d       = beat_i;
    beat_d.acc1  = beat_i.acc1 ^ (c1_bit_i ? beat_i.mcand : '0);
    beat_d.acc2  = beat_i.acc2 ^ (c2_bit_i ? beat_i.mcand : '0);
    beat_d.mcand = gf_xtime(beat_i.mcand, wide_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      beat_q <= beat_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/gfrse_out.sv]
// ----------------------------------------------------------------------------
// gfrse_out
// Result stage: combines the finished products with the symbols per
// function code and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module gfrse_out (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  input  gfrse_pkg::beat_t               beat_i,
  output logic                           ready_o,
  output logic                           valid_o,
  output logic [gfrse_pkg::SymW-1:0]     res_first_o,
  output logic [gfrse_pkg::SymW-1:0]     res_second_o,
  output logic                           last_o,
  input  wire logic                      ready_i
);
  import gfrse_pkg::*;

  logic            valid_q;
  logic [SymW-1:0] r1_q, r1_d;
  logic [SymW-1:0] r2_q, r2_d;
  logic            last_q;

  assign ready_o      = !valid_q || ready_i;
  assign valid_o      = valid_q;
  assign res_first_o  = r1_q;
  assign res_second_o = r2_q;
  assign last_o       = last_q;

  always_comb begin
    r1_d = '0;
    r2_d = '0;
    case (beat_i.func)
      FuncMac: begin
        r1_d = beat_i.dst ^ beat_i.acc1;
      end
      FuncDualMac: begin
        r1_d = beat_i.dst ^ beat_i.acc1;
        r2_d = beat_i.dst2 ^ beat_i.acc2;
      end
      FuncMul: begin
        r1_d = beat_i.acc1;
      end
      FuncXor: begin
        r1_d = beat_i.src ^ beat_i.dst;
      end
      FuncBfly: begin
        r1_d = beat_i.src ^ beat_i.acc1;
        r2_d = beat_i.dst ^ beat_i.src ^ beat_i.acc1;
      end
      FuncInvBfly: begin
        r1_d = beat_i.src ^ beat_i.acc1;
        r2_d = beat_i.dst ^ beat_i.src;
      end
      default: begin
        r1_d = '0;
        r2_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      r1_q   <= r1_d;
      r2_q   <= r2_d;
      last_q <= beat_i.last;
    end
  end

endmodule

`default_nettype wire

[rtl/core/gf_region_symbol_engine.sv]
// ----------------------------------------------------------------------------
// gf_region_symbol_engine
// Galois-field region symbol engine for GF(2^8) and GF(2^16).
// ----------------------------------------------------------------------------
// One symbol beat enters per cycle unless the output stalls. The products
// come from a row of 16 multiplier cells, one per coefficient
// bit, each a register stage, followed by a registered result stage. Every
// stage has its own handshake, so bubbles close up and the input keeps
// taking beats while a finished result waits at the output. The field mode
// and coefficients must only be written while no beats are in flight.
`default_nettype none

module gf_region_symbol_engine (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [gfrse_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [gfrse_pkg::SymW-1:0]    cfg_data_i,
  gfrse_in_if.sink                           in_ch,
  gfrse_out_if.source                        out_ch
);
  import gfrse_pkg::*;

  logic            field_mode_q;
  logic [SymW-1:0] coef_first_q;
  logic [SymW-1:0] coef_second_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_mode_q  <= 1'b0;
      coef_first_q  <= '0;
      coef_second_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgFieldMode:  field_mode_q  <= cfg_data_i[0];
        CfgCoefFirst:  coef_first_q  <= cfg_data_i;
        CfgCoefSecond: coef_second_q <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  logic [SymW-1:0] sym_mask;
  logic [SymW-1:0] src_m, dst_m, dst2_m;
  beat_t           entry;

  assign sym_mask = field_mode_q ? 16'hFFFF : 16'h00FF;
  assign src_m    = in_ch.sym_src & sym_mask;
  assign dst_m    = in_ch.sym_dst & sym_mask;
  assign dst2_m   = in_ch.sym_dst_two & sym_mask;

  always_comb begin
    entry.func  = func_e'(in_ch.func);
    entry.src   = src_m;
    entry.dst   = dst_m;
    entry.dst2  = dst2_m;
    entry.last  = in_ch.last_in;
    entry.acc1  = '0;
    entry.acc2  = '0;
    case (func_e'(in_ch.func))
      FuncBfly:    entry.mcand = dst_m;
      FuncInvBfly: entry.mcand = src_m ^ dst_m;
      default:     entry.mcand = src_m;
    endcase
  end

  logic  valid_s [NumCells+1];
  logic  rdy_s   [NumCells+1];
  beat_t beat_s  [NumCells+1];

  assign valid_s[0]  = in_ch.valid;
  assign beat_s[0]   = entry;
  assign in_ch.ready = rdy_s[0];

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    localparam logic InNarrow = (k < NarrowCells);
    logic bit_en;
    assign bit_en = field_mode_q | InNarrow;

    gfrse_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .wide_i   (field_mode_q),
      .c1_bit_i (coef_first_q[k] & bit_en),
      .c2_bit_i (coef_second_q[k] & bit_en),
      .valid_i  (valid_s[k]),
      .beat_i   (beat_s[k]),
      .ready_o  (rdy_s[k]),
      .valid_o  (valid_s[k+1]),
      .beat_o   (beat_s[k+1]),
      .ready_i  (rdy_s[k+1])
    );
  end

  gfrse_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_s[NumCells]),
    .beat_i       (beat_s[NumCells]),
    .ready_o      (rdy_s[NumCells]),
    .valid_o      (out_ch.valid),
    .res_first_o  (out_ch.res_first),
    .res_second_o (out_ch.res_second),
    .last_o       (out_ch.last_out),
    .ready_i      (out_ch.ready)
  );

endmodule

`default_nettype wire

[rtl/core/gfrse_chk.sv]
// ----------------------------------------------------------------------------
// gfrse_chk
// Port-level checks on the symbol engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gfrse_chk (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_i,
  input wire logic                       out_valid_i,
  input wire logic                       out_ready_i,
  input wire logic [gfrse_pkg::SymW-1:0] res_first_i,
  input wire logic [gfrse_pkg::SymW-1:0] res_second_i,
  input wire logic                       last_out_i
);
  import gfrse_pkg::*;

  localparam int Depth = NumCells + 1;
  localparam int CntW  = $clog2(Depth + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            in_beat, out_beat;

  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (in_beat && !out_beat) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!in_beat && out_beat) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(res_first_i) && $stable(res_second_i) && $stable(last_out_i))
    else $error("stalled result beat changed");

  a_in_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with output side empty");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != '0)
    else $error("result beat without a matching input beat");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("more beats in flight than pipeline stages");

endmodule

bind gf_region_symbol_engine gfrse_chk u_gfrse_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_ch.valid),
  .in_ready_i   (in_ch.ready),
  .out_valid_i  (out_ch.valid),
  .out_ready_i  (out_ch.ready),
  .res_first_i  (out_ch.res_first),
  .res_second_i (out_ch.res_second),
  .last_out_i   (out_ch.last_out)
);

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the GF(2^8)/GF(2^16) region symbol engine. Symbol
// beats are fed through the input channel from a queue. Each accepted beat is
// turned into its expected result by a local field-arithmetic predictor. The
// output monitor checks every result beat in order against those results.
// The run is split into phases, each setting a field mode, coefficients
// and an idle pattern.
// ----------------------------------------------------------------------------

module testbench;
  import gfrse_pkg::*;

  localparam int                 StallLimit   = 2000;
  localparam int                 PhaseCount   = 9;
  localparam int                 PhaseSymbols = 78;
  localparam int                 TailCycles   = 24;
  localparam logic [FuncW-1:0]   FuncSpare6   = 3'd6;
  localparam logic [FuncW-1:0]   FuncSpare7   = 3'd7;
  localparam logic [CfgIdxW-1:0] CfgUnused    = 2'd3;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [SymW-1:0]  src;
    logic [SymW-1:0]  dst;
    logic [SymW-1:0]  dst2;
    logic             last;
  } sym_beat_t;

  typedef struct packed {
    logic [SymW-1:0] res_first;
    logic [SymW-1:0] res_second;
    logic            last;
  } sym_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [SymW-1:0]    cfg_data_i;

  gfrse_in_if  in_ch ();
  gfrse_out_if out_ch ();

  gf_region_symbol_engine DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  always #2 clk_i = ~clk_i;

  sym_beat_t   symbols_to_send[$];
  sym_result_t results_due[$];
  sym_beat_t   beat_on_wire;
  logic        field_wide;
  logic [15:0] coef_first;
  logic [15:0] coef_second;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          errors;
  int          stall_cycles;

  function automatic logic [15:0] gf_product(input logic [15:0] a, input logic [15:0] c,
                                             input logic wide);
    logic [15:0] acc;
    logic [15:0] m;
    acc = '0;
    m = wide ? a : {8'h00, a[7:0]};
    for (int k = 0; k < 16; k++) begin
      if (wide || k < 8) begin
        if (c[k]) acc ^= m;
        if (wide) m = {m[14:0], 1'b0} ^ (m[15] ? Red16 : 16'h0000);
        else m = {8'h00, m[6:0], 1'b0} ^ (m[7] ? {8'h00, Red8} : 16'h0000);
      end
    end
    return acc;
  endfunction

  function automatic sym_result_t region_op_result(input sym_beat_t b);
    sym_result_t r;
    logic [15:0] mask;
    logic [15:0] s;
    logic [15:0] d;
    logic [15:0] d2;
    logic [15:0] c1;
    logic [15:0] c2;
    mask = field_wide ? 16'hFFFF : 16'h00FF;
    s = b.src & mask;
    d = b.dst & mask;
    d2 = b.dst2 & mask;
    c1 = coef_first & mask;
    c2 = coef_second & mask;
    r.res_first = '0;
    r.res_second = '0;
    r.last = b.last;
    case (b.func)
      FuncMac: r.res_first = d ^ gf_product(s, c1, field_wide);
      FuncDualMac: begin
        r.res_first = d ^ gf_product(s, c1, field_wide);
        r.res_second = d2 ^ gf_product(s, c2, field_wide);
      end
      FuncMul: r.res_first = gf_product(s, c1, field_wide);
      FuncXor: r.res_first = s ^ d;
      FuncBfly: begin
        r.res_first = s ^ gf_product(d, c1, field_wide);
        r.res_second = d ^ r.res_first;
      end
      FuncInvBfly: begin
        r.res_second = d ^ s;
        r.res_first = s ^ gf_product(r.res_second, c1, field_wide);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) results_due.push_back(region_op_result(beat_on_wire));
      if (!in_ch.valid || in_ch.ready) begin
        if (symbols_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          beat_on_wire = symbols_to_send.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.func        <= beat_on_wire.func;
          in_ch.sym_src     <= beat_on_wire.src;
          in_ch.sym_dst     <= beat_on_wire.dst;
          in_ch.sym_dst_two <= beat_on_wire.dst2;
          in_ch.last_in     <= beat_on_wire.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk_i or negedge rst_ni) begin
    sym_result_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat %h/%h last %b",
                                    out_ch.res_first, out_ch.res_second, out_ch.last_out));
        end else begin
          want = results_due.pop_front();
          if (out_ch.res_first !== want.res_first)
            report_mismatch($sformatf("res_first %h, expected %h",
                                      out_ch.res_first, want.res_first));
          if (out_ch.res_second !== want.res_second)
            report_mismatch($sformatf("res_second %h, expected %h",
                                      out_ch.res_second, want.res_second));
          if (out_ch.last_out !== want.last)
            report_mismatch($sformatf("last_out %b, expected %b", out_ch.last_out, want.last));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CfgFieldMode:  field_wide = data[0];
      CfgCoefFirst:  coef_first = data;
      CfgCoefSecond: coef_second = data;
      default: ;
    endcase
  endtask

  task automatic configure(input logic wide, input logic [15:0] c1, input logic [15:0] c2);
    write_reg(CfgFieldMode, {15'($urandom), wide});
    write_reg(CfgCoefFirst, c1);
    write_reg(CfgCoefSecond, c2);
    write_reg(CfgUnused, 16'($urandom));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic add_symbol(input logic [FuncW-1:0] f, input logic [15:0] s,
                            input logic [15:0] d, input logic [15:0] d2, input logic l);
    symbols_to_send.push_back('{func: f, src: s, dst: d, dst2: d2, last: l});
  endtask

  task automatic wait_drained();
    while (symbols_to_send.size() > 0 || in_ch.valid || results_due.size() > 0)
      @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_symbol();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h0080;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [FuncW-1:0] pick_func();
    if ($urandom_range(19) == 0) return $urandom_range(1) ? FuncSpare7 : FuncSpare6;
    return FuncW'($urandom_range(FuncInvBfly));
  endfunction

  initial begin
    logic        wide;
    logic [15:0] c1;
    logic [15:0] c2;
    errors = 0;
    stall_cycles = 0;
    field_wide = 1'b0;
    coef_first = '0;
    coef_second = '0;
    send_idle_pct = 36;
    recv_idle_pct = 78;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgFieldMode;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.func = FuncMac;
    in_ch.sym_src = '0;
    in_ch.sym_dst = '0;
    in_ch.sym_dst_two = '0;
    in_ch.last_in = 1'b0;
    out_ch.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: every func code against extreme symbols, wide field
    configure(1'b1, 16'hFFFF, 16'h8001);
    for (int f = 0; f < 8; f++) add_symbol(FuncW'(f), 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1);
    for (int f = 0; f <= FuncInvBfly; f++)
      add_symbol(FuncW'(f), 16'h8000, 16'hFFFF, 16'h0000, 1'b0);
    add_symbol(FuncMul, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0);
    add_symbol(FuncXor, 16'hA5A5, 16'hA5A5, 16'h0000, 1'b1);
    add_symbol(FuncInvBfly, 16'h1234, 16'h1234, 16'h0000, 1'b0);
    wait_drained();

    for (int p = 0; p < PhaseCount; p++) begin
      case (p / 3)
        0: begin send_idle_pct = 36; recv_idle_pct = 78; end
        1: begin send_idle_pct = 78; recv_idle_pct = 36; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (p)
        0: begin wide = 1'b0; c1 = 16'h0000; c2 = 16'h0000; end
        1: begin wide = 1'b0; c1 = 16'hFFFF; c2 = 16'hFF80; end
        2: begin wide = 1'b1; c1 = 16'hFFFF; c2 = 16'hFFFF; end
        3: begin wide = 1'b1; c1 = 16'h0001; c2 = 16'h8000; end
        default: begin wide = 1'($urandom_range(1)); c1 = 16'($urandom); c2 = 16'($urandom); end
      endcase
      configure(wide, c1, c2);
      for (int i = 0; i < PhaseSymbols; i++)
        add_symbol(pick_func(), pick_symbol(), pick_symbol(), pick_symbol(),
                   $urandom_range(7) == 0);
      wait_drained();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (results_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", results_due.size()));
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/gfrse_pkg.sv
rtl/core/gfrse_if.sv
rtl/core/gfrse_cell.sv
rtl/core/gfrse_out.sv
rtl/core/gf_region_symbol_engine.sv
rtl/core/gfrse_chk.sv
tb/testbench.sv
